@@ rtl/dsa_sign_and_verify_core_assert.svh @@
// Assertion macros for the DSA core modules; the sequencer (dsa_ctrl) includes them.
// Depends on nothing; included by files that check their own logic.
`ifndef DSA_SIGN_AND_VERIFY_CORE_ASSERT_SVH
`define DSA_SIGN_AND_VERIFY_CORE_ASSERT_SVH

// same-cycle implication
`define DSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/dsa_pkg.sv @@
// Shared types, constants and the sequencer program of the DSA core.
// Depends on nothing; used by every RTL module of the core.
package dsa_pkg;

   localparam int MOD_W        = 31;
   localparam int REQ_TDATA_W  = ((2 * MOD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((3 * MOD_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int PC_W         = 6;
   localparam int MDIV_CNT_W   = $clog2(2 * MOD_W + 1);

   typedef logic [MOD_W-1:0] val_type;
   typedef logic [PC_W-1:0]  pc_type;

   typedef enum logic [1:0] {
      CSR_MODULUS_P,
      CSR_MODULUS_Q,
      CSR_GENERATOR_G,
      CSR_PRIVATE_KEY_X
   } csr_idx_type;

   typedef enum logic [4:0] {
      OPND_ZERO, OPND_ONE, OPND_HM, OPND_K, OPND_G, OPND_X, OPND_P, OPND_Q,
      OPND_Y, OPND_R, OPND_S, OPND_W, OPND_U1, OPND_U2, OPND_SUM, OPND_T1,
      OPND_TMP, OPND_V, OPND_BASE, OPND_ACC, OPND_PR, OPND_CR, OPND_PT, OPND_CT,
      OPND_QUO
   } opnd_type;

   typedef enum logic [1:0] {
      MODSEL_P,
      MODSEL_Q,
      MODSEL_CR
   } mod_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_MUL,
      CMD_MOVE,
      CMD_SETEXP,
      CMD_SHIFTEXP,
      CMD_ADDMOD,
      CMD_TSTEP
   } cmd_type;

   typedef enum logic [3:0] {
      BR_NEXT,
      BR_JUMP,
      BR_IF_EXPZ,
      BR_IF_EXPEVEN,
      BR_IF_CRZ,
      BR_IF_CRONE,
      BR_CALL,
      BR_RET,
      BR_END
   } br_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } ctrl_state_type;

   typedef struct packed {
      cmd_type  cmd;
      opnd_type src_a;
      opnd_type src_b;
      mod_type  modsel;
      opnd_type dst;
      br_type   br;
      pc_type   target;
   } uinstr_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      cmd_type  cmd;
      opnd_type src_a;
      opnd_type src_b;
      mod_type  modsel;
      opnd_type dst;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_zero;
      logic exp_lsb;
      logic cr_zero;
      logic cr_one;
   } dp_stat_type;

   typedef struct packed {
      val_type p;
      val_type q;
      val_type g;
      val_type x;
   } cfg_type;

   typedef struct packed {
      logic    start;
      val_type a;
      val_type b;
      val_type m;
   } mdiv_req_type;

   typedef struct packed {
      logic    done;
      val_type rem;
      val_type quo;
   } mdiv_rsp_type;

   localparam pc_type PC_POW      = PC_W'(29);
   localparam pc_type PC_POW_LOOP = PC_W'(30);
   localparam pc_type PC_POW_SQR  = PC_W'(33);
   localparam pc_type PC_POW_RET  = PC_W'(35);
   localparam pc_type PC_INV      = PC_W'(36);
   localparam pc_type PC_INV_LOOP = PC_W'(39);
   localparam pc_type PC_INV_ZERO = PC_W'(46);
   localparam pc_type PC_INV_ONE  = PC_W'(47);

   function automatic uinstr_type mk(cmd_type c, opnd_type a, opnd_type b, mod_type m,
                                     opnd_type d, br_type br, pc_type t);
      uinstr_type u;
      u.cmd    = c;
      u.src_a  = a;
      u.src_b  = b;
      u.modsel = m;
      u.dst    = d;
      u.br     = br;
      u.target = t;
      return u;
   endfunction

   function automatic uinstr_type mul(opnd_type a, opnd_type b, mod_type m, opnd_type d);
      return mk(CMD_MUL, a, b, m, d, BR_NEXT, '0);
   endfunction

   function automatic uinstr_type mov(opnd_type a, opnd_type d, br_type br);
      return mk(CMD_MOVE, a, OPND_ZERO, MODSEL_Q, d, br, '0);
   endfunction

   function automatic uinstr_type ctl(cmd_type c, opnd_type a, br_type br, pc_type t);
      return mk(c, a, OPND_ZERO, MODSEL_Q, OPND_ZERO, br, t);
   endfunction

   function automatic uinstr_type ucode(pc_type pc);
      uinstr_type u;
      case (int'(pc))
         0:  u = mul(OPND_G, OPND_ONE, MODSEL_P, OPND_BASE);
         1:  u = ctl(CMD_SETEXP, OPND_X, BR_NEXT, '0);
         2:  u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_POW);
         3:  u = mov(OPND_ACC, OPND_Y, BR_NEXT);
         4:  u = mul(OPND_G, OPND_ONE, MODSEL_P, OPND_BASE);
         5:  u = ctl(CMD_SETEXP, OPND_K, BR_NEXT, '0);
         6:  u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_POW);
         7:  u = mul(OPND_ACC, OPND_ONE, MODSEL_Q, OPND_R);
         8:  u = mul(OPND_HM, OPND_ONE, MODSEL_Q, OPND_SUM);
         9:  u = mul(OPND_X, OPND_R, MODSEL_Q, OPND_TMP);
         10: u = ctl(CMD_ADDMOD, OPND_ZERO, BR_NEXT, '0);
         11: u = mul(OPND_K, OPND_ONE, MODSEL_Q, OPND_CR);
         12: u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_INV);
         13: u = mul(OPND_TMP, OPND_SUM, MODSEL_Q, OPND_S);
         14: u = mul(OPND_S, OPND_ONE, MODSEL_Q, OPND_CR);
         15: u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_INV);
         16: u = mov(OPND_TMP, OPND_W, BR_NEXT);
         17: u = mul(OPND_HM, OPND_W, MODSEL_Q, OPND_U1);
         18: u = mul(OPND_R, OPND_W, MODSEL_Q, OPND_U2);
         19: u = mul(OPND_G, OPND_ONE, MODSEL_P, OPND_BASE);
         20: u = ctl(CMD_SETEXP, OPND_U1, BR_NEXT, '0);
         21: u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_POW);
         22: u = mov(OPND_ACC, OPND_T1, BR_NEXT);
         23: u = mul(OPND_Y, OPND_ONE, MODSEL_P, OPND_BASE);
         24: u = ctl(CMD_SETEXP, OPND_U2, BR_NEXT, '0);
         25: u = ctl(CMD_NONE, OPND_ZERO, BR_CALL, PC_POW);
         26: u = mul(OPND_T1, OPND_ACC, MODSEL_P, OPND_TMP);
         27: u = mul(OPND_TMP, OPND_ONE, MODSEL_Q, OPND_V);
         28: u = ctl(CMD_NONE, OPND_ZERO, BR_END, '0);
         29: u = mul(OPND_ONE, OPND_ONE, MODSEL_P, OPND_ACC);
         30: u = ctl(CMD_NONE, OPND_ZERO, BR_IF_EXPZ, PC_POW_RET);
         31: u = ctl(CMD_NONE, OPND_ZERO, BR_IF_EXPEVEN, PC_POW_SQR);
         32: u = mul(OPND_ACC, OPND_BASE, MODSEL_P, OPND_ACC);
         33: u = mul(OPND_BASE, OPND_BASE, MODSEL_P, OPND_BASE);
         34: u = ctl(CMD_SHIFTEXP, OPND_ZERO, BR_JUMP, PC_POW_LOOP);
         35: u = ctl(CMD_NONE, OPND_ZERO, BR_RET, '0);
         36: u = mov(OPND_Q, OPND_PR, BR_NEXT);
         37: u = mov(OPND_ZERO, OPND_PT, BR_NEXT);
         38: u = mov(OPND_ONE, OPND_CT, BR_NEXT);
         39: u = ctl(CMD_NONE, OPND_ZERO, BR_IF_CRZ, PC_INV_ZERO);
         40: u = ctl(CMD_NONE, OPND_ZERO, BR_IF_CRONE, PC_INV_ONE);
         41: u = mul(OPND_PR, OPND_ONE, MODSEL_CR, OPND_TMP);
         42: u = mov(OPND_CR, OPND_PR, BR_NEXT);
         43: u = mov(OPND_TMP, OPND_CR, BR_NEXT);
         44: u = mul(OPND_QUO, OPND_CT, MODSEL_Q, OPND_TMP);
         45: u = ctl(CMD_TSTEP, OPND_ZERO, BR_JUMP, PC_INV_LOOP);
         46: u = mov(OPND_ZERO, OPND_TMP, BR_RET);
         47: u = mov(OPND_CT, OPND_TMP, BR_RET);
         default: u = ctl(CMD_NONE, OPND_ZERO, BR_END, '0);
      endcase
      return u;
   endfunction

endpackage

@@ rtl/dsa_mdiv.sv @@
// Multiply-and-divide unit: one registered product, then restoring division a bit per cycle.
// Depends on dsa_pkg.
module dsa_mdiv (
   input  logic                  clock,
   input  logic                  reset,
   input  dsa_pkg::mdiv_req_type req,
   output dsa_pkg::mdiv_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dsa_pkg::MDIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*dsa_pkg::MOD_W-1:0]       prod_ff, prod_in;
   dsa_pkg::val_type                  rem_ff, rem_in;
   dsa_pkg::val_type                  m_ff, m_in;
   logic [dsa_pkg::MOD_W:0]           part;
   logic [dsa_pkg::MOD_W:0]           diff;
   logic                              ge;

   assign part = {rem_ff, prod_ff[2*dsa_pkg::MOD_W-1]};
   assign diff = part - {1'b0, m_ff};
   assign ge   = part >= {1'b0, m_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      m_in    = m_ff;
      if (req.start) begin
         prod_in = (2*dsa_pkg::MOD_W)'(req.a) * (2*dsa_pkg::MOD_W)'(req.b);
         m_in    = req.m;
         rem_in  = '0;
         cnt_in  = dsa_pkg::MDIV_CNT_W'(2 * dsa_pkg::MOD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[dsa_pkg::MOD_W-1:0] : part[dsa_pkg::MOD_W-1:0];
         prod_in = {prod_ff[2*dsa_pkg::MOD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == dsa_pkg::MDIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      m_ff    <= m_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = (m_ff == '0) ? '0 : rem_ff;
   assign rsp.quo  = (m_ff == '0) ? '0 : prod_ff[dsa_pkg::MOD_W-1:0];

endmodule

@@ rtl/dsa_datapath.sv @@
// Operand registers, operand selection and the shared multiply-divide unit.
// Depends on dsa_pkg and dsa_mdiv.
module dsa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dsa_pkg::cfg_type     cfg,
   input  dsa_pkg::val_type     in_hash,
   input  dsa_pkg::val_type     in_nonce,
   input  dsa_pkg::dp_cmd_type  cmd,
   output dsa_pkg::dp_stat_type stat,
   output dsa_pkg::val_type     res_r,
   output dsa_pkg::val_type     res_s,
   output dsa_pkg::val_type     res_v
);

   dsa_pkg::val_type hm_ff, hm_in, k_ff, k_in, y_ff, y_in, r_ff, r_in, s_ff, s_in;
   dsa_pkg::val_type w_ff, w_in, u1_ff, u1_in, u2_ff, u2_in, sum_ff, sum_in;
   dsa_pkg::val_type t1_ff, t1_in, tmp_ff, tmp_in, v_ff, v_in, base_ff, base_in;
   dsa_pkg::val_type acc_ff, acc_in, pr_ff, pr_in, cr_ff, cr_in, pt_ff, pt_in;
   dsa_pkg::val_type ct_ff, ct_in, quo_ff, quo_in, exp_ff, exp_in;
   dsa_pkg::opnd_type dst_ff, dst_in;

   dsa_pkg::val_type      a_val, b_val, m_val, wr_data;
   dsa_pkg::opnd_type     wr_dst;
   logic                  wr_en;
   logic [dsa_pkg::MOD_W:0] add_sum, add_red, sub_low;
   dsa_pkg::mdiv_req_type mreq;
   dsa_pkg::mdiv_rsp_type mrsp;

   function automatic dsa_pkg::val_type pick(dsa_pkg::opnd_type o,
      dsa_pkg::val_type hm, dsa_pkg::val_type k, dsa_pkg::val_type y, dsa_pkg::val_type r,
      dsa_pkg::val_type s, dsa_pkg::val_type w, dsa_pkg::val_type u1, dsa_pkg::val_type u2,
      dsa_pkg::val_type sm, dsa_pkg::val_type t1, dsa_pkg::val_type tp, dsa_pkg::val_type v,
      dsa_pkg::val_type bs, dsa_pkg::val_type ac, dsa_pkg::val_type pr, dsa_pkg::val_type cr,
      dsa_pkg::val_type pt, dsa_pkg::val_type ct, dsa_pkg::val_type qu, dsa_pkg::cfg_type c);
      dsa_pkg::val_type res;
      case (o)
         dsa_pkg::OPND_ZERO: res = '0;
         dsa_pkg::OPND_ONE:  res = dsa_pkg::MOD_W'(1);
         dsa_pkg::OPND_HM:   res = hm;
         dsa_pkg::OPND_K:    res = k;
         dsa_pkg::OPND_G:    res = c.g;
         dsa_pkg::OPND_X:    res = c.x;
         dsa_pkg::OPND_P:    res = c.p;
         dsa_pkg::OPND_Q:    res = c.q;
         dsa_pkg::OPND_Y:    res = y;
         dsa_pkg::OPND_R:    res = r;
         dsa_pkg::OPND_S:    res = s;
         dsa_pkg::OPND_W:    res = w;
         dsa_pkg::OPND_U1:   res = u1;
         dsa_pkg::OPND_U2:   res = u2;
         dsa_pkg::OPND_SUM:  res = sm;
         dsa_pkg::OPND_T1:   res = t1;
         dsa_pkg::OPND_TMP:  res = tp;
         dsa_pkg::OPND_V:    res = v;
         dsa_pkg::OPND_BASE: res = bs;
         dsa_pkg::OPND_ACC:  res = ac;
         dsa_pkg::OPND_PR:   res = pr;
         dsa_pkg::OPND_CR:   res = cr;
         dsa_pkg::OPND_PT:   res = pt;
         dsa_pkg::OPND_CT:   res = ct;
         dsa_pkg::OPND_QUO:  res = qu;
         default:            res = '0;
      endcase
      return res;
   endfunction

   always_comb begin
      a_val = pick(cmd.src_a, hm_ff, k_ff, y_ff, r_ff, s_ff, w_ff, u1_ff, u2_ff, sum_ff,
                   t1_ff, tmp_ff, v_ff, base_ff, acc_ff, pr_ff, cr_ff, pt_ff, ct_ff, quo_ff,
                   cfg);
      b_val = pick(cmd.src_b, hm_ff, k_ff, y_ff, r_ff, s_ff, w_ff, u1_ff, u2_ff, sum_ff,
                   t1_ff, tmp_ff, v_ff, base_ff, acc_ff, pr_ff, cr_ff, pt_ff, ct_ff, quo_ff,
                   cfg);
      case (cmd.modsel)
         dsa_pkg::MODSEL_P:  m_val = cfg.p;
         dsa_pkg::MODSEL_Q:  m_val = cfg.q;
         dsa_pkg::MODSEL_CR: m_val = cr_ff;
         default:            m_val = cfg.q;
      endcase
   end

   assign mreq.start = cmd.issue && (cmd.cmd == dsa_pkg::CMD_MUL);
   assign mreq.a     = a_val;
   assign mreq.b     = b_val;
   assign mreq.m     = m_val;

   dsa_mdiv u_mdiv (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   assign add_sum = {1'b0, sum_ff} + {1'b0, tmp_ff};
   assign add_red = (add_sum >= {1'b0, cfg.q}) ? add_sum - {1'b0, cfg.q} : add_sum;
   assign sub_low = {1'b0, pt_ff} + {1'b0, cfg.q} - {1'b0, tmp_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_dst  = cmd.dst;
      wr_data = a_val;
      dst_in  = dst_ff;
      quo_in  = quo_ff;
      exp_in  = exp_ff;
      hm_in   = hm_ff;
      k_in    = k_ff;
      if (mrsp.done) begin
         wr_en   = 1'b1;
         wr_dst  = dst_ff;
         wr_data = mrsp.rem;
         quo_in  = mrsp.quo;
      end
      if (cmd.load) begin
         hm_in = in_hash;
         k_in  = in_nonce;
      end
      if (cmd.issue) begin
         case (cmd.cmd)
            dsa_pkg::CMD_MUL:      dst_in = cmd.dst;
            dsa_pkg::CMD_MOVE:     wr_en  = 1'b1;
            dsa_pkg::CMD_SETEXP:   exp_in = a_val;
            dsa_pkg::CMD_SHIFTEXP: exp_in = exp_ff >> 1;
            dsa_pkg::CMD_ADDMOD: begin
               wr_en   = 1'b1;
               wr_dst  = dsa_pkg::OPND_SUM;
               wr_data = add_red[dsa_pkg::MOD_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      y_in = y_ff; r_in = r_ff; s_in = s_ff; w_in = w_ff; u1_in = u1_ff; u2_in = u2_ff;
      sum_in = sum_ff; t1_in = t1_ff; tmp_in = tmp_ff; v_in = v_ff; base_in = base_ff;
      acc_in = acc_ff; pr_in = pr_ff; cr_in = cr_ff; pt_in = pt_ff; ct_in = ct_ff;
      if (wr_en) begin
         case (wr_dst)
            dsa_pkg::OPND_Y:    y_in    = wr_data;
            dsa_pkg::OPND_R:    r_in    = wr_data;
            dsa_pkg::OPND_S:    s_in    = wr_data;
            dsa_pkg::OPND_W:    w_in    = wr_data;
            dsa_pkg::OPND_U1:   u1_in   = wr_data;
            dsa_pkg::OPND_U2:   u2_in   = wr_data;
            dsa_pkg::OPND_SUM:  sum_in  = wr_data;
            dsa_pkg::OPND_T1:   t1_in   = wr_data;
            dsa_pkg::OPND_TMP:  tmp_in  = wr_data;
            dsa_pkg::OPND_V:    v_in    = wr_data;
            dsa_pkg::OPND_BASE: base_in = wr_data;
            dsa_pkg::OPND_ACC:  acc_in  = wr_data;
            dsa_pkg::OPND_PR:   pr_in   = wr_data;
            dsa_pkg::OPND_CR:   cr_in   = wr_data;
            dsa_pkg::OPND_PT:   pt_in   = wr_data;
            dsa_pkg::OPND_CT:   ct_in   = wr_data;
            default: ;
         endcase
      end
      if (cmd.issue && (cmd.cmd == dsa_pkg::CMD_TSTEP)) begin
         pt_in = ct_ff;
         ct_in = (pt_ff >= tmp_ff) ? pt_ff - tmp_ff : sub_low[dsa_pkg::MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      hm_ff <= hm_in; k_ff <= k_in; y_ff <= y_in; r_ff <= r_in; s_ff <= s_in;
      w_ff <= w_in; u1_ff <= u1_in; u2_ff <= u2_in; sum_ff <= sum_in; t1_ff <= t1_in;
      tmp_ff <= tmp_in; v_ff <= v_in; base_ff <= base_in; acc_ff <= acc_in;
      pr_ff <= pr_in; cr_ff <= cr_in; pt_ff <= pt_in; ct_ff <= ct_in; quo_ff <= quo_in;
      exp_ff <= exp_in; dst_ff <= dst_in;
   end

   assign stat.mul_done = mrsp.done;
   assign stat.exp_zero = (exp_ff == '0);
   assign stat.exp_lsb  = exp_ff[0];
   assign stat.cr_zero  = (cr_ff == '0);
   assign stat.cr_one   = (cr_ff == dsa_pkg::MOD_W'(1));

   assign res_r = r_ff;
   assign res_s = s_ff;
   assign res_v = v_ff;

endmodule

@@ rtl/dsa_ctrl.sv @@
// Sequencer: walks the program in dsa_pkg, issues datapath commands, waits on the multiplier.
// Depends on dsa_pkg and the assertion macro header.
`include "dsa_sign_and_verify_core_assert.svh"

module dsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 out_free,
   output logic                 res_load,
   input  dsa_pkg::dp_stat_type stat,
   output dsa_pkg::dp_cmd_type  cmd
);

   dsa_pkg::ctrl_state_type state_ff, state_in;
   dsa_pkg::pc_type         pc_ff, pc_in, ret_ff, ret_in, pc_next;
   dsa_pkg::uinstr_type     instr;

   assign instr   = dsa_pkg::ucode(pc_ff);
   assign pc_next = pc_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      ret_in     = ret_ff;
      req_ready  = 1'b0;
      res_load   = 1'b0;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      cmd.cmd    = instr.cmd;
      cmd.src_a  = instr.src_a;
      cmd.src_b  = instr.src_b;
      cmd.modsel = instr.modsel;
      cmd.dst    = instr.dst;
      case (state_ff)
         dsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = '0;
               state_in = dsa_pkg::ST_ISSUE;
            end
         end
         dsa_pkg::ST_ISSUE: begin
            if (instr.cmd == dsa_pkg::CMD_MUL) begin
               cmd.issue = 1'b1;
               state_in  = dsa_pkg::ST_WAIT;
            end else if (instr.br == dsa_pkg::BR_END) begin
               if (out_free) begin
                  res_load = 1'b1;
                  state_in = dsa_pkg::ST_IDLE;
               end
            end else begin
               cmd.issue = 1'b1;
               case (instr.br)
                  dsa_pkg::BR_JUMP:       pc_in = instr.target;
                  dsa_pkg::BR_IF_EXPZ:    pc_in = stat.exp_zero ? instr.target : pc_next;
                  dsa_pkg::BR_IF_EXPEVEN: pc_in = !stat.exp_lsb ? instr.target : pc_next;
                  dsa_pkg::BR_IF_CRZ:     pc_in = stat.cr_zero ? instr.target : pc_next;
                  dsa_pkg::BR_IF_CRONE:   pc_in = stat.cr_one ? instr.target : pc_next;
                  dsa_pkg::BR_CALL: begin
                     ret_in = pc_next;
                     pc_in  = instr.target;
                  end
                  dsa_pkg::BR_RET:        pc_in = ret_ff;
                  default:                pc_in = pc_next;
               endcase
            end
         end
         dsa_pkg::ST_WAIT: begin
            if (stat.mul_done) begin
               pc_in    = pc_next;
               state_in = dsa_pkg::ST_ISSUE;
            end
         end
         default: state_in = dsa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsa_pkg::ST_IDLE;
         pc_ff    <= '0;
         ret_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         ret_ff   <= ret_in;
      end
   end

   `DSA_ASSERT_NEXT(a_wait_hold_pc, clock, reset, state_ff == dsa_pkg::ST_WAIT && !stat.mul_done, $stable(pc_ff))
   `DSA_ASSERT_IMPLY(a_load_into_free, clock, reset, res_load, out_free)
   `DSA_ASSERT_NEXT(a_load_to_idle, clock, reset, res_load, state_ff == dsa_pkg::ST_IDLE)
   `DSA_ASSERT_NEXT(a_mul_waits, clock, reset, cmd.issue && cmd.cmd == dsa_pkg::CMD_MUL, state_ff == dsa_pkg::ST_WAIT)

endmodule

@@ rtl/dsa_sign_and_verify_core.sv @@
// DSA sign-and-verify core: for each request beat (message hash, nonce k) it returns one response
// beat with r = (g^k mod p) mod q, s = k^-1 (hash + x r) mod q (zero when k has no inverse mod q)
// and the self-check value v, which equals r for a valid signature. p, q, g and x are set through
// the csr_ port at byte addresses 0, 4, 8 and 12 and must only be written while the core is idle.
// Every modular multiply runs on one shared multiply-divide unit: a 31x31 product followed by a
// restoring reduction; the modular add and the Euclid coefficient step use their own adders. An
// item takes four square-and-multiply exponentiations and two extended-Euclid inverses in
// sequence. One item is processed at a time; the next one is accepted as soon as the finished
// result sits in the response register.
// Depends on dsa_pkg, dsa_ctrl and dsa_datapath.
module dsa_sign_and_verify_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dsa_pkg::REQ_TDATA_W-1:0]   req_tdata,   // message_hash, nonce_k
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dsa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // sig_r, sig_s, verify_v
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dsa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   dsa_pkg::cfg_type     cfg_ff, cfg_in;
   dsa_pkg::csr_idx_type csr_idx;
   dsa_pkg::val_type     wr_val, rd_val;
   dsa_pkg::dp_cmd_type  cmd;
   dsa_pkg::dp_stat_type stat;
   dsa_pkg::val_type     res_r, res_s, res_v;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [dsa_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 out_free, res_load;

   assign csr_pready = 1'b1;
   assign csr_idx    = dsa_pkg::csr_idx_type'(csr_paddr[3:2]);
   assign wr_val     = csr_pwdata[dsa_pkg::MOD_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            dsa_pkg::CSR_MODULUS_P:     cfg_in.p = wr_val;
            dsa_pkg::CSR_MODULUS_Q:     cfg_in.q = wr_val;
            dsa_pkg::CSR_GENERATOR_G:   cfg_in.g = wr_val;
            dsa_pkg::CSR_PRIVATE_KEY_X: cfg_in.x = wr_val;
            default: ;
         endcase
      end
      case (csr_idx)
         dsa_pkg::CSR_MODULUS_P:     rd_val = cfg_ff.p;
         dsa_pkg::CSR_MODULUS_Q:     rd_val = cfg_ff.q;
         dsa_pkg::CSR_GENERATOR_G:   rd_val = cfg_ff.g;
         dsa_pkg::CSR_PRIVATE_KEY_X: rd_val = cfg_ff.x;
         default:                    rd_val = '0;
      endcase
   end

   assign csr_prdata = dsa_pkg::CSR_DATA_W'(rd_val);

   assign out_free = !rsp_valid_ff || rsp_tready;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .res_load  (res_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_hash  (req_tdata[dsa_pkg::MOD_W-1:0]),
      .in_nonce (req_tdata[2*dsa_pkg::MOD_W-1:dsa_pkg::MOD_W]),
      .cmd      (cmd),
      .stat     (stat),
      .res_r    (res_r),
      .res_s    (res_s),
      .res_v    (res_v)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dsa_pkg::RSP_TDATA_W'({res_v, res_s, res_r});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p     <= dsa_pkg::MOD_W'(23);
         cfg_ff.q     <= dsa_pkg::MOD_W'(11);
         cfg_ff.g     <= dsa_pkg::MOD_W'(4);
         cfg_ff.x     <= dsa_pkg::MOD_W'(3);
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ bench/tb_dsa_sign_and_verify_core.sv @@
// Self-checking bench for the DSA sign-and-verify core: random and corner requests, CSR phases.
// Predicts r, s and v per request beat and compares against response beats in order.
// Depends on dsa_pkg and dsa_sign_and_verify_core.
`timescale 1ns / 100ps

module tb_dsa_sign_and_verify_core;

   typedef struct packed {
      dsa_pkg::val_type k;
      dsa_pkg::val_type hm;
   } req_type;

   typedef struct packed {
      dsa_pkg::val_type v;
      dsa_pkg::val_type s;
      dsa_pkg::val_type r;
   } sig_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dsa_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dsa_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dsa_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [dsa_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [dsa_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   dsa_sign_and_verify_core i_dut (.*);

   dsa_pkg::cfg_type grp;
   req_type  pending_reqs[$];
   sig_type  expected_sigs[$];
   int       errors = 0;
   bit       calm = 0;
   bit       drained_hold = 0;
   int       req_gap = 0;
   int       rsp_gap = 0;
   int       sent = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("FAILURE");
      $finish;
   end

   function automatic longint unsigned rmod(longint unsigned a, longint unsigned m);
      return (m == 0) ? 0 : a % m;
   endfunction

   function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
                                            longint unsigned m);
      return (m == 0) ? 0 : ((a % m) * (b % m)) % m;
   endfunction

   function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
                                            longint unsigned m);
      longint unsigned acc;
      if (m == 0) return 0;
      acc = 1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) acc = mulm(acc, b, m);
         b = mulm(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned invm(longint unsigned b, longint unsigned m);
      longint pr, cr, pt, ct, qo, t, mm;
      if (m == 0) return 0;
      mm = longint'(m);
      pr = mm;
      cr = longint'(b % m);
      pt = 0;
      ct = 1;
      forever begin
         if (cr == 0) return 0;
         if (cr == 1) begin
            t = ct % mm;
            if (t < 0) t += mm;
            return longint'(t);
         end
         qo = pr / cr;
         t = pr - qo * cr;
         pr = cr;
         cr = t;
         t = pt - qo * ct;
         pt = ct;
         ct = t;
      end
   endfunction

   function automatic sig_type sign_and_check(req_type rq);
      longint unsigned p, q, g, x, y, r, s, w, u1, u2, sum;
      sig_type o;
      p = grp.p; q = grp.q; g = grp.g; x = grp.x;
      y = powm(g, x, p);
      r = rmod(powm(g, rq.k, p), q);
      sum = rmod(rmod(rq.hm, q) + mulm(x, r, q), q);
      s = mulm(invm(rq.k, q), sum, q);
      w = invm(s, q);
      u1 = mulm(rq.hm, w, q);
      u2 = mulm(r, w, q);
      o.r = dsa_pkg::val_type'(r);
      o.s = dsa_pkg::val_type'(s);
      o.v = dsa_pkg::val_type'(rmod(mulm(powm(g, u1, p), powm(y, u2, p), p), q));
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_sigs.push_back(
               sign_and_check(req_type'(req_tdata[2*dsa_pkg::MOD_W-1:0])));
            sent <= sent + 1;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !drained_hold) begin
               req_tdata  <= {{(dsa_pkg::REQ_TDATA_W - 2*dsa_pkg::MOD_W){1'b0}},
                              pending_reqs.pop_front()};
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sig_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = sig_type'(rsp_tdata[3*dsa_pkg::MOD_W-1:0]);
            if (expected_sigs.size() == 0) begin
               $display("%0t unexpected beat %h", $time, got);
               errors++;
            end else begin
               want = expected_sigs.pop_front();
               if (got.r !== want.r) begin
                  $display("%0t r exp %0d got %0d", $time, want.r, got.r);
                  errors++;
               end
               if (got.s !== want.s) begin
                  $display("%0t s exp %0d got %0d", $time, want.s, got.s);
                  errors++;
               end
               if (got.v !== want.v) begin
                  $display("%0t v exp %0d got %0d", $time, want.v, got.v);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) rsp_gap <= $urandom_range(1, 17);
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_sigs.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(dsa_pkg::csr_idx_type idx, dsa_pkg::val_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= dsa_pkg::CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         dsa_pkg::CSR_MODULUS_P:     grp.p = value;
         dsa_pkg::CSR_MODULUS_Q:     grp.q = value;
         dsa_pkg::CSR_GENERATOR_G:   grp.g = value;
         dsa_pkg::CSR_PRIVATE_KEY_X: grp.x = value;
         default: ;
      endcase
   endtask

   task automatic set_group(dsa_pkg::val_type p, dsa_pkg::val_type q, dsa_pkg::val_type g,
                            dsa_pkg::val_type x);
      csr_write(dsa_pkg::CSR_MODULUS_P, p);
      csr_write(dsa_pkg::CSR_MODULUS_Q, q);
      csr_write(dsa_pkg::CSR_GENERATOR_G, g);
      csr_write(dsa_pkg::CSR_PRIVATE_KEY_X, x);
   endtask

   function automatic dsa_pkg::val_type rnd_val();
      case ($urandom_range(0, 4))
         0: return dsa_pkg::val_type'($urandom_range(0, 3));
         1: return dsa_pkg::val_type'({dsa_pkg::MOD_W{1'b1}} - $urandom_range(0, 3));
         default: return dsa_pkg::val_type'($urandom);
      endcase
   endfunction

   task automatic push_random(int n, bit small_vals);
      req_type rq;
      repeat (n) begin
         rq.hm = small_vals ? dsa_pkg::val_type'($urandom_range(0, 40)) : rnd_val();
         rq.k  = small_vals ? dsa_pkg::val_type'($urandom_range(0, 40)) : rnd_val();
         pending_reqs.push_back(rq);
      end
   endtask

   initial begin
      req_type rq;
      dsa_pkg::val_type ext[4];
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      grp.p = 23; grp.q = 11; grp.g = 4; grp.x = 3;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ext = '{dsa_pkg::val_type'(0), dsa_pkg::val_type'(1), dsa_pkg::val_type'(11),
              {dsa_pkg::MOD_W{1'b1}}};
      foreach (ext[i]) foreach (ext[j]) begin
         rq.hm = ext[i];
         rq.k  = ext[j];
         pending_reqs.push_back(rq);
      end
      push_random(6, 1);
      wait_drained();

      set_group(dsa_pkg::val_type'(2147483647), dsa_pkg::val_type'(1073741823),
                dsa_pkg::val_type'(7), dsa_pkg::val_type'(123456789));
      push_random(15, 0);
      wait_drained();

      drained_hold = 1;
      push_random(5, 0);
      set_group(dsa_pkg::val_type'(0), dsa_pkg::val_type'(0), dsa_pkg::val_type'(0),
                dsa_pkg::val_type'(0));
      drained_hold = 0;
      wait_drained();

      set_group(dsa_pkg::val_type'(1), dsa_pkg::val_type'(1), {dsa_pkg::MOD_W{1'b1}},
                {dsa_pkg::MOD_W{1'b1}});
      push_random(5, 0);
      wait_drained();

      set_group(dsa_pkg::val_type'(2), dsa_pkg::val_type'(2), dsa_pkg::val_type'(1),
                dsa_pkg::val_type'(1));
      push_random(5, 1);
      wait_drained();

      set_group(dsa_pkg::val_type'(607), dsa_pkg::val_type'(101), dsa_pkg::val_type'(64),
                dsa_pkg::val_type'($urandom_range(0, 100)));
      push_random(20, 0);
      push_random(10, 1);
      wait_drained();

      set_group(rnd_val(), rnd_val(), rnd_val(), rnd_val());
      push_random(15, 0);
      wait_drained();

      calm = 1;
      set_group(dsa_pkg::val_type'(23), dsa_pkg::val_type'(11), dsa_pkg::val_type'(4),
                dsa_pkg::val_type'(3));
      push_random(10, 1);
      wait_drained();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_mdiv.sv
rtl/dsa_datapath.sv
rtl/dsa_ctrl.sv
rtl/dsa_sign_and_verify_core.sv
bench/tb_dsa_sign_and_verify_core.sv
